// File: rtl/assert_macros.svh
// Assertion macros for the top-level RTL file, clocked on clk and held off during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge of clk outside reset.
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: rtl/jse_pkg.sv
// Shared types and character constants of the JSON string escaper.
package jse_pkg;

  // How the back end spells out one queued job.
  typedef enum logic [1:0] {
    KIND_CHAR,  // one character, sent as is
    KIND_ESC2,  // backslash and one letter
    KIND_U4,    // \uXXXX
    KIND_PAIR   // \uXXXX\uXXXX surrogate pair
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] hi;  // character or escape letter in [7:0], or first hex word
    logic [15:0] lo;  // second hex word of a surrogate pair
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_A      = 8'h41;

endpackage

// File: rtl/jse_front.sv
// Front end: takes input bytes, gathers UTF-8 sequences and classifies each value into a job.
module jse_front
  import jse_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       ensure_ascii,
  input  logic       in_accept,
  input  logic [7:0] data_byte,
  input  logic       end_of_string,
  output logic       push,
  output job_t       push_job
);

  logic [20:0] partial_cp, partial_cp_next;
  logic [1:0]  due, due_next;
  logic        emit;
  logic [20:0] value;
  logic        wide;

  function automatic job_t classify(input logic [20:0] v, input logic wd);
    job_t        j;
    logic [7:0]  esc;
    logic [20:0] d;
    j.kind = KIND_CHAR;
    j.hi   = {8'h00, v[7:0]};
    j.lo   = '0;
    d      = v - 21'h010000;
    case (v)
      21'h000022: esc = CH_QUOTE;
      21'h00005C: esc = CH_BSLASH;
      21'h000008: esc = CH_B;
      21'h00000C: esc = CH_F;
      21'h00000A: esc = CH_N;
      21'h00000D: esc = CH_R;
      21'h000009: esc = CH_T;
      default:    esc = 8'h00;
    endcase
    if (esc != 8'h00) begin
      j.kind = KIND_ESC2;
      j.hi   = {8'h00, esc};
    end else if (v <= 21'h00001F) begin
      j.kind = KIND_U4;
      j.hi   = v[15:0];
    end else if (!wd || v <= 21'h00007F) begin
      j.kind = KIND_CHAR;
    end else if (v <= 21'h00FFFF) begin
      j.kind = KIND_U4;
      j.hi   = v[15:0];
    end else begin
      j.kind = KIND_PAIR;
      j.hi   = 16'hD800 + {5'b00000, d[20:10]};
      j.lo   = {6'b110111, d[9:0]};
    end
    return j;
  endfunction

  always_comb begin
    partial_cp_next = partial_cp;
    due_next        = due;
    emit            = 1'b0;
    value           = {13'd0, data_byte};
    wide            = ensure_ascii;
    if (!ensure_ascii) begin
      // raw mode drops any pending sequence
      partial_cp_next = '0;
      due_next        = '0;
      emit            = 1'b1;
    end else if (due != 2'd0) begin
      value           = {partial_cp[14:0], data_byte[5:0]};
      due_next        = due - 2'd1;
      partial_cp_next = value;
      if (due == 2'd1) begin
        emit            = 1'b1;
        partial_cp_next = '0;
      end
    end else if (data_byte >= 8'hC0) begin
      if (data_byte >= 8'hF0) begin
        partial_cp_next = {18'd0, data_byte[2:0]};
        due_next        = 2'd3;
      end else if (data_byte >= 8'hE0) begin
        partial_cp_next = {17'd0, data_byte[3:0]};
        due_next        = 2'd2;
      end else begin
        partial_cp_next = {16'd0, data_byte[4:0]};
        due_next        = 2'd1;
      end
    end else begin
      emit = 1'b1;
    end
    if (end_of_string) begin
      partial_cp_next = '0;
      due_next        = '0;
    end
  end

  assign push     = in_accept && emit;
  assign push_job = classify(value, wide);

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_cp <= '0;
      due        <= '0;
    end else if (in_accept) begin
      partial_cp <= partial_cp_next;
      due        <= due_next;
    end
  end

endmodule

// File: rtl/jse_queue.sv
// Short job queue between the front end and the character sequencer.
module jse_queue
  import jse_pkg::*;
#(
  parameter int Depth = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  job_t      push_job,
  input  logic      pop,
  output job_t      head_job,
  output q_status_t status
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  job_t            mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign status.full  = (count == FullCnt);
  assign status.empty = (count == '0);
  assign head_job     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/jse_back.sv
// Back end: spells out the head job one character a beat into the output register.
module jse_back
  import jse_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  job_t       head_job,
  input  logic       q_empty,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       run_last
);

  logic [3:0]  idx;
  logic [3:0]  last_idx;
  logic [3:0]  pos;
  logic [15:0] word;
  logic [3:0]  nib;
  logic [7:0]  ch;
  logic        advance;
  logic        at_last;

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) begin
      return CH_ZERO + {4'd0, n};
    end
    return CH_A + {4'd0, n} - 8'd10;
  endfunction

  always_comb begin
    case (head_job.kind)
      KIND_CHAR: last_idx = 4'd0;
      KIND_ESC2: last_idx = 4'd1;
      KIND_U4:   last_idx = 4'd5;
      KIND_PAIR: last_idx = 4'd11;
      default:   last_idx = 4'd0;
    endcase
  end

  always_comb begin
    pos  = (idx >= 4'd6) ? idx - 4'd6 : idx;
    word = (idx >= 4'd6) ? head_job.lo : head_job.hi;
    case (pos)
      4'd2:    nib = word[15:12];
      4'd3:    nib = word[11:8];
      4'd4:    nib = word[7:4];
      default: nib = word[3:0];
    endcase
    case (head_job.kind)
      KIND_CHAR: ch = head_job.hi[7:0];
      KIND_ESC2: ch = (idx == 4'd0) ? CH_BSLASH : head_job.hi[7:0];
      default: begin
        if (pos == 4'd0) begin
          ch = CH_BSLASH;
        end else if (pos == 4'd1) begin
          ch = CH_U;
        end else begin
          ch = hex_char(nib);
        end
      end
    endcase
  end

  assign advance = !out_valid || out_ready;
  assign at_last = (idx == last_idx);
  assign pop     = advance && !q_empty && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= !q_empty;
      if (!q_empty) begin
        idx <= at_last ? 4'd0 : idx + 4'd1;
      end
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (advance && !q_empty) begin
      out_char <= ch;
      run_last <= at_last;
    end
  end

endmodule

// File: rtl/json_string_escaper_unit.sv
// JSON string escaper: takes one string byte a beat and sends the JSON-escaped text one
// character a beat. With ensure_ascii low each byte is escaped alone; with it high UTF-8
// sequences are gathered into a code point and non-ASCII code points leave as \uXXXX or a
// surrogate pair, and a sequence cut short by tlast is dropped. A byte is taken every cycle
// while the job queue has room; while m_axis_tready is high the output side sends one
// character per cycle. A plain byte yields one character, a two-letter escape two, \uXXXX
// six and a surrogate pair twelve, all set by the character sequencer of the back end. Lead
// and middle bytes of a sequence produce no output. The queue of QUEUE_DEPTH jobs lets the
// input run ahead of an escape. A job is queued first, then its characters are registered.
`include "assert_macros.svh"

module json_string_escaper_unit
  import jse_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,      // ensure_ascii
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tlast,   // end_of_string
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_char
  output logic       m_axis_tlast    // run_last
);

  logic      ensure_ascii;
  logic      in_accept;
  logic      q_push;
  job_t      q_push_job;
  logic      q_pop;
  job_t      q_head;
  q_status_t q_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      ensure_ascii <= 1'b0;
    end else if (cfg_we) begin
      ensure_ascii <= cfg_wdata;
    end
  end

  assign s_axis_tready = !q_status.full;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  jse_front u_front (
    .clk           (clk),
    .rst           (rst),
    .ensure_ascii  (ensure_ascii),
    .in_accept     (in_accept),
    .data_byte     (s_axis_tdata),
    .end_of_string (s_axis_tlast),
    .push          (q_push),
    .push_job      (q_push_job)
  );

  jse_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_push_job),
    .pop      (q_pop),
    .head_job (q_head),
    .status   (q_status)
  );

  jse_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_job  (q_head),
    .q_empty   (q_status.empty),
    .pop       (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_char  (m_axis_tdata),
    .run_last  (m_axis_tlast)
  );

  `ASSERT_IMPLY(a_no_push_when_full, q_push, !q_status.full, "job pushed into full queue")
  `ASSERT_IMPLY(a_no_pop_when_empty, q_pop, !q_status.empty, "job popped from empty queue")
  `ASSERT_IMPLY(a_raw_byte_queued, in_accept && !ensure_ascii, q_push, "raw byte made no job")
  `ASSERT_CLK(a_pop_loads_last, q_pop |=> (m_axis_tvalid && m_axis_tlast), "pop without last beat")

endmodule
